@@ sv/kpn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kpn_pkg;

  // Column and row line levels
  localparam logic [3:0] LINES_ALL_HIGH = 4'hF;
  localparam logic [3:0] ROW0_LOW       = 4'b1110;

  // Entry width defaults; the result port is fixed at 32 bits
  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int ENTRY_W             = 32;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_DELAY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DELAY = 1'b1;
  localparam logic [CFG_W-1:0] PRESS_DELAY_RESET   = 16'd500;
  localparam logic [CFG_W-1:0] RELEASE_DELAY_RESET = 16'd200;

  // ASCII codes with special meaning
  localparam logic [7:0] KEY_ZERO   = 8'h30; // '0'
  localparam logic [7:0] KEY_NINE   = 8'h39; // '9'
  localparam logic [7:0] KEY_PLUS   = 8'h2B; // '+', deletes last digit
  localparam logic [7:0] KEY_CLEAR  = 8'h43; // 'C'
  localparam logic [7:0] KEY_EQUALS = 8'h3D; // '='

  typedef enum logic [2:0] {
    PH_PRESS_DELAY   = 3'd0,
    PH_WAIT_PRESS    = 3'd1,
    PH_ROW_SCAN      = 3'd2,
    PH_WAIT_RELEASE  = 3'd3,
    PH_RELEASE_DELAY = 3'd4
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] press_ticks;
    logic [CFG_W-1:0] release_ticks;
  } delay_cfg_t;

  // Per-tick result of the scanner
  typedef struct packed {
    logic [3:0] drive;
    logic       apply;
    logic [7:0] key;
  } scan_res_t;

  // Per-tick flags of the entry logic
  typedef struct packed {
    logic       key_event;
    logic [7:0] key_code;
    logic       entry_done;
  } entry_flags_t;

endpackage

`default_nettype wire

@@ sv/keypad_scan_number_entry.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// -------   -------------------   ---------------------------------------------
// input     in_valid / in_ready   column_sample
// output    out_valid / out_ready row_drive, key_event, key_code, entry_done,
//                                 entry_value
// config    cfg_we                cfg_index, cfg_data (no wait, no read-back)
//
// One scan tick per cycle sustained while the output is not stalled; a tick's
// result passes the input register, then the result register, before it can
// transfer out.
// Synchronous active-high reset: press delay phase, empty entry, delays 500/200.
// A stalled result holds the result register; the input register keeps taking
// a tick as long as the result register is free or being emptied.
// A delete divides by ten in a 16-bit-per-cycle unit started at every applied
// key; it finishes before the next key can apply.
module keypad_scan_number_entry #(
  parameter int VALUE_WIDTH = kpn_pkg::DEFAULT_VALUE_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [3:0]                    column_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [3:0]                    row_drive,
  output logic                               key_event,
  output logic      [7:0]                    key_code,
  output logic                               entry_done,
  output logic      [kpn_pkg::ENTRY_W-1:0]   entry_value,
  input  wire logic                          cfg_we,
  input  wire logic [kpn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [kpn_pkg::CFG_W-1:0]     cfg_data
);

  localparam int EXT_W = (VALUE_WIDTH > kpn_pkg::ENTRY_W) ? VALUE_WIDTH : kpn_pkg::ENTRY_W;

  kpn_pkg::delay_cfg_t   dly;
  kpn_pkg::scan_res_t    scan_res;
  kpn_pkg::entry_flags_t flags;

  logic                   in_full;
  logic [3:0]             in_cols;
  logic                   step;
  logic [VALUE_WIDTH-1:0] shown;
  logic [EXT_W-1:0]       shown_ext;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dly.press_ticks   <= kpn_pkg::PRESS_DELAY_RESET;
      dly.release_ticks <= kpn_pkg::RELEASE_DELAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kpn_pkg::REG_PRESS_DELAY:   dly.press_ticks   <= cfg_data;
        kpn_pkg::REG_RELEASE_DELAY: dly.release_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tick advances from input register into result register
  assign step     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cols <= column_sample;
    end
  end

  kpn_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cols (in_cols),
    .dly  (dly),
    .res  (scan_res)
  );

  kpn_entry #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_entry (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .res   (scan_res),
    .flags (flags),
    .shown (shown)
  );

  assign shown_ext = EXT_W'(shown);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      row_drive   <= scan_res.drive;
      key_event   <= flags.key_event;
      key_code    <= flags.key_code;
      entry_done  <= flags.entry_done;
      entry_value <= shown_ext[kpn_pkg::ENTRY_W-1:0];
    end
  end

  // A finished entry is always reported together with its key transfer
  a_done_event: assert property (@(posedge clk) disable iff (rst)
    (out_valid && entry_done) |-> key_event)
    else $error("entry done without key event");

  // Key code is zero on ticks without an applied key
  a_code_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !key_event) |-> (key_code == 8'd0))
    else $error("key code set without key event");

endmodule

`default_nettype wire

@@ sv/kpn_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kpn_scan (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic [3:0]         cols,
  input  kpn_pkg::delay_cfg_t     dly,
  output kpn_pkg::scan_res_t      res
);

  kpn_pkg::phase_t phase, phase_next;
  logic [1:0]  scan_row, scan_row_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  held_key, held_key_next;

  logic [15:0] limit;
  logic [15:0] tick_inc;
  logic        dly_done;

  function automatic logic [1:0] first_low(input logic [3:0] c);
    logic [1:0] idx;
    idx = 2'd0;
    priority if (!c[0]) idx = 2'd0;
    else if (!c[1]) idx = 2'd1;
    else if (!c[2]) idx = 2'd2;
    else if (!c[3]) idx = 2'd3;
    else idx = 2'd0;
    return idx;
  endfunction

  // Keypad layout: 7 8 9 / | 4 5 6 X | 1 2 3 - | C 0 = +
  function automatic logic [7:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
    logic [7:0] k;
    unique case ({row, col})
      4'h0: k = 8'h37;
      4'h1: k = 8'h38;
      4'h2: k = 8'h39;
      4'h3: k = 8'h2F;
      4'h4: k = 8'h34;
      4'h5: k = 8'h35;
      4'h6: k = 8'h36;
      4'h7: k = 8'h58;
      4'h8: k = 8'h31;
      4'h9: k = 8'h32;
      4'hA: k = 8'h33;
      4'hB: k = 8'h2D;
      4'hC: k = kpn_pkg::KEY_CLEAR;
      4'hD: k = kpn_pkg::KEY_ZERO;
      4'hE: k = kpn_pkg::KEY_EQUALS;
      default: k = kpn_pkg::KEY_PLUS;
    endcase
    return k;
  endfunction

  // Shared delay counter; a zero delay still takes one tick
  assign limit    = (phase == kpn_pkg::PH_RELEASE_DELAY) ? dly.release_ticks : dly.press_ticks;
  assign tick_inc = (tick_count < limit) ? tick_count + 16'd1 : tick_count;
  assign dly_done = (tick_inc >= limit);

  // Next state and per-tick result
  always_comb begin
    phase_next      = phase;
    scan_row_next   = scan_row;
    tick_count_next = tick_count;
    held_key_next   = held_key;
    res             = '0;
    unique case (phase)
      kpn_pkg::PH_WAIT_PRESS: begin
        if (cols != kpn_pkg::LINES_ALL_HIGH) begin
          scan_row_next = 2'd0;
          phase_next    = kpn_pkg::PH_ROW_SCAN;
          res.drive     = kpn_pkg::ROW0_LOW;
        end
      end
      kpn_pkg::PH_ROW_SCAN: begin
        if (cols != kpn_pkg::LINES_ALL_HIGH) begin
          held_key_next = key_lookup(scan_row, first_low(cols));
          phase_next    = kpn_pkg::PH_WAIT_RELEASE;
        end else if (scan_row == 2'd3) begin
          // no row matched: ground all rows, wait again
          scan_row_next = 2'd0;
          phase_next    = kpn_pkg::PH_WAIT_PRESS;
        end else begin
          scan_row_next = scan_row + 2'd1;
          res.drive     = ~(4'b0001 << scan_row_next);
        end
      end
      kpn_pkg::PH_WAIT_RELEASE: begin
        if (cols == kpn_pkg::LINES_ALL_HIGH) begin
          tick_count_next = 16'd0;
          phase_next      = kpn_pkg::PH_RELEASE_DELAY;
        end
      end
      kpn_pkg::PH_RELEASE_DELAY: begin
        tick_count_next = dly_done ? 16'd0 : tick_inc;
        if (dly_done) begin
          res.apply  = 1'b1;
          res.key    = held_key;
          phase_next = kpn_pkg::PH_PRESS_DELAY;
        end
      end
      default: begin
        // press delay
        tick_count_next = dly_done ? 16'd0 : tick_inc;
        phase_next      = dly_done ? kpn_pkg::PH_WAIT_PRESS : kpn_pkg::PH_PRESS_DELAY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= kpn_pkg::PH_PRESS_DELAY;
      scan_row   <= 2'd0;
      tick_count <= 16'd0;
      held_key   <= 8'd0;
    end else if (step) begin
      phase      <= phase_next;
      scan_row   <= scan_row_next;
      tick_count <= tick_count_next;
      held_key   <= held_key_next;
    end
  end

  // A key is only applied out of the release delay, with all rows grounded
  a_apply_phase: assert property (@(posedge clk) disable iff (rst)
    res.apply |-> (phase == kpn_pkg::PH_RELEASE_DELAY) && (res.drive == 4'd0))
    else $error("key applied outside release delay");

endmodule

`default_nettype wire

@@ sv/kpn_div10.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Divide by ten, 16 bits per cycle, most significant chunk first
module kpn_div10 #(
  parameter int WIDTH = kpn_pkg::DEFAULT_VALUE_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] src,
  output logic      [WIDTH-1:0] quot,
  output logic                  busy
);

  localparam int CHUNK = 16;
  localparam int STEPS = (WIDTH + CHUNK - 1) / CHUNK;
  localparam int PAD_W = STEPS * CHUNK;
  localparam int CNT_W = $clog2(STEPS + 1);

  // ceil(2^23 / 10); exact for dividends below 10 * 2^16
  localparam logic [19:0] RECIP10 = 20'd838861;

  logic [PAD_W-1:0] src_sh;
  logic [PAD_W-1:0] quo_sh;
  logic [3:0]       rem;
  logic [CNT_W-1:0] cnt;

  logic [19:0] part;
  logic [39:0] prod;
  logic [15:0] q_chunk;
  logic [19:0] r_full;

  // One chunk: remainder so far followed by the next 16 source bits
  assign part    = {rem, src_sh[PAD_W-1 -: CHUNK]};
  assign prod    = 40'(part) * 40'(RECIP10);
  assign q_chunk = prod[38:23];
  assign r_full  = part - 20'(q_chunk) * 20'd10;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_sh <= '0;
      quo_sh <= '0;
      rem    <= 4'd0;
      cnt    <= '0;
    end else if (start) begin
      src_sh <= PAD_W'(src);
      quo_sh <= '0;
      rem    <= 4'd0;
      cnt    <= CNT_W'(STEPS);
    end else if (cnt != '0) begin
      src_sh <= src_sh << CHUNK;
      quo_sh <= (quo_sh << CHUNK) | PAD_W'(q_chunk);
      rem    <= r_full[3:0];
      cnt    <= cnt - CNT_W'(1);
    end
  end

  assign quot = quo_sh[WIDTH-1:0];
  assign busy = (cnt != '0);

endmodule

`default_nettype wire

@@ sv/kpn_entry.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kpn_entry #(
  parameter int VALUE_WIDTH = kpn_pkg::DEFAULT_VALUE_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  kpn_pkg::scan_res_t          res,
  output kpn_pkg::entry_flags_t       flags,
  output logic      [VALUE_WIDTH-1:0] shown
);

  logic [VALUE_WIDTH-1:0] acc, acc_next, acc_upd;
  logic [7:0]             digit_count, digit_count_next;
  logic [7:0]             last_digit, last_digit_next;
  logic                   finish;
  logic                   is_digit;
  logic [7:0]             digit_code;
  logic [VALUE_WIDTH-1:0] acc_append;
  logic [VALUE_WIDTH-1:0] acc_div10;
  logic                   div_busy;

  assign is_digit   = (res.key >= kpn_pkg::KEY_ZERO) && (res.key <= kpn_pkg::KEY_NINE);
  assign digit_code = res.key - kpn_pkg::KEY_ZERO;
  // acc*10 + digit, wrapping at the value width
  assign acc_append = (acc << 3) + (acc << 1) + VALUE_WIDTH'(digit_code[3:0]);

  // Quotient of the stored value, refreshed after every applied key
  kpn_div10 #(
    .WIDTH (VALUE_WIDTH)
  ) u_div10 (
    .clk   (clk),
    .rst   (rst),
    .start (step && res.apply),
    .src   (acc_next),
    .quot  (acc_div10),
    .busy  (div_busy)
  );

  // Apply one key to the entry
  always_comb begin
    acc_upd          = acc;
    digit_count_next = digit_count;
    last_digit_next  = last_digit;
    flags            = '0;
    finish           = 1'b0;
    if (res.apply) begin
      flags.key_event = 1'b1;
      flags.key_code  = res.key;
      priority if (is_digit) begin
        acc_upd         = acc_append;
        last_digit_next = res.key;
        if (digit_count != 8'hFF) begin
          digit_count_next = digit_count + 8'd1;
        end
      end else if (res.key == kpn_pkg::KEY_PLUS) begin
        if (digit_count != 8'd0) begin
          acc_upd          = acc_div10;
          digit_count_next = digit_count - 8'd1;
        end
      end else if (res.key == kpn_pkg::KEY_CLEAR) begin
        acc_upd          = '0;
        digit_count_next = 8'd0;
      end else begin
        if (res.key == kpn_pkg::KEY_EQUALS) begin
          flags.key_code = last_digit;
        end
        flags.entry_done = 1'b1;
        finish           = 1'b1;
      end
    end
    // finished entry reports its value, then starts over
    if (finish) begin
      digit_count_next = 8'd0;
      last_digit_next  = 8'd0;
    end
  end

  assign shown    = acc_upd;
  assign acc_next = finish ? '0 : acc_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      digit_count <= 8'd0;
      last_digit  <= 8'd0;
    end else if (step) begin
      acc         <= acc_next;
      digit_count <= digit_count_next;
      last_digit  <= last_digit_next;
    end
  end

  // The quotient must be settled before a delete can use it
  a_div_ready: assert property (@(posedge clk) disable iff (rst)
    (step && res.apply && (res.key == kpn_pkg::KEY_PLUS) && (digit_count != 8'd0))
      |-> !div_busy)
    else $error("delete applied while divide still running");

  // A finishing key leaves an empty entry behind
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (step && flags.entry_done) |=> (acc == '0) && (digit_count == 8'd0))
    else $error("entry not cleared after finish");

endmodule

`default_nettype wire
